>>> src/tvot_pkg.sv
`default_nettype none

package tvot_pkg;

	localparam int COORD_W    = 24;
	localparam int UNIT_W     = 23;
	localparam int INDEX_BITS = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int EPS_LSB      = 4;
	localparam int HALF_EPS_LSB = 2;

	// internal widths, exact for the full input ranges
	localparam int V_W  = COORD_W + 1;        // vertex in grid frame
	localparam int E_W  = V_W + 1;            // edge vector
	localparam int PR_W = INDEX_BITS + UNIT_W; // index * unit
	localparam int P_W  = PR_W + 1;           // box corner, signed
	localparam int D_W  = P_W + 1;            // corner minus vertex
	localparam int DP_W = UNIT_W + 1;         // box edge, unsigned
	localparam int N_W  = 2 * E_W + 1;        // normal component
	localparam int Q_W  = D_W + 1;            // plane test offset
	localparam int NL_W = 26;                 // low split of normal
	localparam int NH_W = N_W - NL_W;         // high split of normal
	localparam int PP_W = NH_W + Q_W;         // partial product
	localparam int PC_W = N_W + Q_W;          // full product
	localparam int PS_W = PC_W + 2;           // sum of three
	localparam int EG_W = E_W + D_W;          // edge * offset
	localparam int G_W  = EG_W + 1;
	localparam int T_W  = DP_W + 1 + E_W;     // box edge * edge
	localparam int F_W  = G_W + 2;            // edge function

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_UNIT_X   = 3'd3,
		CFG_UNIT_Y   = 3'd4,
		CFG_UNIT_Z   = 3'd5
	} cfg_reg_t;

	localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(4096);

endpackage

`default_nettype wire

>>> src/triangle_voxel_overlap_test_unit.sv
// Triangle / voxel overlap test (conservative separating-axis form).
// Command channel: one transaction (three vertices and a voxel index triple)
// is taken at each clock edge where start is high; busy is always low, so a
// new transaction may be issued every cycle.
// Result channel: done is high for exactly one cycle with overlap and the
// four sub-test flags; the receiver cannot hold it off.
// Results leave in issue order.
// Throughput: one transaction per cycle. The pipeline has eight register
// stages; the plane test's 53 x 36 bit products are split into two
// 27 x 36 bit partial products per component, which sets the depth.
// Configuration: cfg_write, cfg_index, cfg_data write origin and unit
// registers; write only while no transaction is in flight.
// Reset: arst_n clears all valid bits and loads origin 0, unit 4096.
`default_nettype none

module triangle_voxel_overlap_test_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [tvot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tvot_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert0_x,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert0_y,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert0_z,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert1_x,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert1_y,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert1_z,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert2_x,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert2_y,
	input  wire logic signed [tvot_pkg::COORD_W-1:0] vert2_z,
	input  wire logic [tvot_pkg::INDEX_BITS-1:0]    voxel_x,
	input  wire logic [tvot_pkg::INDEX_BITS-1:0]    voxel_y,
	input  wire logic [tvot_pkg::INDEX_BITS-1:0]    voxel_z,
	output logic                                    done,
	output logic                                    overlap,
	output logic                                    plane_pass,
	output logic                                    xy_pass,
	output logic                                    yz_pass,
	output logic                                    zx_pass
);

	localparam int V_W  = tvot_pkg::V_W;
	localparam int E_W  = tvot_pkg::E_W;
	localparam int PR_W = tvot_pkg::PR_W;
	localparam int P_W  = tvot_pkg::P_W;
	localparam int D_W  = tvot_pkg::D_W;
	localparam int DP_W = tvot_pkg::DP_W;
	localparam int N_W  = tvot_pkg::N_W;
	localparam int Q_W  = tvot_pkg::Q_W;
	localparam int NL_W = tvot_pkg::NL_W;
	localparam int PP_W = tvot_pkg::PP_W;
	localparam int PC_W = tvot_pkg::PC_W;
	localparam int PS_W = tvot_pkg::PS_W;
	localparam int EG_W = tvot_pkg::EG_W;
	localparam int G_W  = tvot_pkg::G_W;
	localparam int T_W  = tvot_pkg::T_W;
	localparam int F_W  = tvot_pkg::F_W;

	function automatic logic signed [F_W-1:0] pos_part(input logic signed [F_W-1:0] x);
		pos_part = (x > 0) ? x : '0;
	endfunction

	assign busy = 1'b0;

	// configuration registers
	logic signed [tvot_pkg::COORD_W-1:0] origin_q [3];
	logic [tvot_pkg::UNIT_W-1:0]         unit_q   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				origin_q[j] <= '0;
				unit_q[j]   <= tvot_pkg::UNIT_RESET;
			end
		end else if (cfg_write) begin
			unique case (tvot_pkg::cfg_reg_t'(cfg_index))
				tvot_pkg::CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				tvot_pkg::CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				tvot_pkg::CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				tvot_pkg::CFG_UNIT_X:   unit_q[0] <= cfg_data[tvot_pkg::UNIT_W-1:0];
				tvot_pkg::CFG_UNIT_Y:   unit_q[1] <= cfg_data[tvot_pkg::UNIT_W-1:0];
				tvot_pkg::CFG_UNIT_Z:   unit_q[2] <= cfg_data[tvot_pkg::UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done   <= vld_s7;
		end
	end

	// stage 1: grid frame, box corner product, box edge
	logic signed [tvot_pkg::COORD_W-1:0] vin [3][3];
	logic [tvot_pkg::INDEX_BITS-1:0]     idx [3];
	logic signed [V_W-1:0]  v_c    [3][3];
	logic [PR_W-1:0]        praw_c [3];
	logic [DP_W-1:0]        dp_c   [3];
	logic signed [V_W-1:0]  v_s1   [3][3];
	logic [PR_W-1:0]        praw_s1[3];
	logic [DP_W-1:0]        dp_s1  [3];

	always_comb begin
		vin[0][0] = vert0_x; vin[0][1] = vert0_y; vin[0][2] = vert0_z;
		vin[1][0] = vert1_x; vin[1][1] = vert1_y; vin[1][2] = vert1_z;
		vin[2][0] = vert2_x; vin[2][1] = vert2_y; vin[2][2] = vert2_z;
		idx[0] = voxel_x; idx[1] = voxel_y; idx[2] = voxel_z;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				v_c[i][j] = V_W'(vin[i][j]) - V_W'(origin_q[j]);
			end
		end
		for (int j = 0; j < 3; j++) begin
			praw_c[j] = PR_W'(idx[j]) * PR_W'(unit_q[j]);
			dp_c[j]   = DP_W'(unit_q[j]) + DP_W'(tvot_pkg::EPS_LSB);
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= v_c;
		praw_s1 <= praw_c;
		dp_s1   <= dp_c;
	end

	// stage 2: edges and corner offsets
	logic signed [P_W-1:0] p_c  [3];
	logic signed [E_W-1:0] e_c  [3][3];
	logic signed [D_W-1:0] d_c  [3][3];
	logic signed [E_W-1:0] e_s2 [3][3];
	logic signed [D_W-1:0] d_s2 [3][3];
	logic [DP_W-1:0]       dp_s2[3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			p_c[j] = $signed({1'b0, praw_s1[j]}) - P_W'(tvot_pkg::HALF_EPS_LSB);
			e_c[0][j] = E_W'(v_s1[1][j]) - E_W'(v_s1[0][j]);
			e_c[1][j] = E_W'(v_s1[2][j]) - E_W'(v_s1[1][j]);
			e_c[2][j] = E_W'(v_s1[0][j]) - E_W'(v_s1[2][j]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				d_c[i][j] = D_W'(p_c[j]) - D_W'(v_s1[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		e_s2  <= e_c;
		d_s2  <= d_c;
		dp_s2 <= dp_s1;
	end

	// stage 3: products
	logic signed [N_W-1:0]  cp0_c [3];
	logic signed [N_W-1:0]  cp1_c [3];
	logic signed [EG_W-1:0] pa_c  [3][3];
	logic signed [EG_W-1:0] pb_c  [3][3];
	logic signed [T_W-1:0]  ta_c  [3][3];
	logic signed [T_W-1:0]  tb_c  [3][3];
	logic signed [N_W-1:0]  cp0_s3[3];
	logic signed [N_W-1:0]  cp1_s3[3];
	logic signed [EG_W-1:0] pa_s3 [3][3];
	logic signed [EG_W-1:0] pb_s3 [3][3];
	logic signed [T_W-1:0]  ta_s3 [3][3];
	logic signed [T_W-1:0]  tb_s3 [3][3];
	logic signed [D_W-1:0]  d0_s3 [3];
	logic [DP_W-1:0]        dp_s3 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cp0_c[j] = N_W'(e_s2[0][(j+1)%3]) * N_W'(e_s2[1][(j+2)%3]);
			cp1_c[j] = N_W'(e_s2[0][(j+2)%3]) * N_W'(e_s2[1][(j+1)%3]);
		end
		// [projection][edge]; projection P uses axes a = P, b = P+1
		for (int pj = 0; pj < 3; pj++) begin
			for (int i = 0; i < 3; i++) begin
				pa_c[pj][i] = EG_W'(e_s2[i][(pj+1)%3]) * EG_W'(d_s2[i][pj]);
				pb_c[pj][i] = EG_W'(e_s2[i][pj]) * EG_W'(d_s2[i][(pj+1)%3]);
				ta_c[pj][i] = T_W'($signed({1'b0, dp_s2[pj]})) *
					T_W'(e_s2[i][(pj+1)%3]);
				tb_c[pj][i] = T_W'($signed({1'b0, dp_s2[(pj+1)%3]})) *
					T_W'(e_s2[i][pj]);
			end
		end
	end

	always_ff @(posedge clk) begin
		cp0_s3 <= cp0_c;
		cp1_s3 <= cp1_c;
		pa_s3  <= pa_c;
		pb_s3  <= pb_c;
		ta_s3  <= ta_c;
		tb_s3  <= tb_c;
		for (int j = 0; j < 3; j++) begin
			d0_s3[j] <= d_s2[0][j];
		end
		dp_s3 <= dp_s2;
	end

	// stage 4: normal and edge cross terms
	logic signed [N_W-1:0] n_c  [3];
	logic signed [G_W-1:0] g_c  [3][3];
	logic signed [N_W-1:0] n_s4 [3];
	logic signed [G_W-1:0] g_s4 [3][3];
	logic signed [T_W-1:0] ta_s4[3][3];
	logic signed [T_W-1:0] tb_s4[3][3];
	logic signed [D_W-1:0] d0_s4[3];
	logic [DP_W-1:0]       dp_s4[3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			n_c[j] = cp0_s3[j] - cp1_s3[j];
		end
		for (int pj = 0; pj < 3; pj++) begin
			for (int i = 0; i < 3; i++) begin
				g_c[pj][i] = G_W'(pb_s3[pj][i]) - G_W'(pa_s3[pj][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		n_s4  <= n_c;
		g_s4  <= g_c;
		ta_s4 <= ta_s3;
		tb_s4 <= tb_s3;
		d0_s4 <= d0_s3;
		dp_s4 <= dp_s3;
	end

	// stage 5: edge functions, plane offsets
	logic                  neg_k;
	logic signed [F_W-1:0] f_c;
	logic signed [F_W-1:0] gx, tax, tbx;
	logic [2:0]            proj_c;
	logic signed [Q_W-1:0] cc;
	logic signed [Q_W-1:0] q1_c [3];
	logic signed [Q_W-1:0] q2_c [3];
	logic [2:0]            proj_s5;
	logic signed [Q_W-1:0] q1_s5[3];
	logic signed [Q_W-1:0] q2_s5[3];
	logic signed [N_W-1:0] n_s5 [3];

	always_comb begin
		proj_c = 3'b111;
		neg_k  = 1'b0;
		f_c    = '0;
		gx     = '0;
		tax    = '0;
		tbx    = '0;
		cc     = '0;
		for (int pj = 0; pj < 3; pj++) begin
			neg_k = n_s4[(pj+2)%3][N_W-1];
			for (int i = 0; i < 3; i++) begin
				gx  = F_W'(g_s4[pj][i]);
				tax = F_W'(ta_s4[pj][i]);
				tbx = F_W'(tb_s4[pj][i]);
				if (neg_k) begin
					f_c = -gx + pos_part(tax) + pos_part(-tbx);
				end else begin
					f_c = gx + pos_part(-tax) + pos_part(tbx);
				end
				if (f_c[F_W-1]) begin
					proj_c[pj] = 1'b0;
				end
			end
		end
		for (int j = 0; j < 3; j++) begin
			cc = (!n_s4[j][N_W-1] && (n_s4[j] != '0)) ?
				$signed(Q_W'(dp_s4[j])) : '0;
			q1_c[j] = Q_W'(d0_s4[j]) + cc;
			q2_c[j] = Q_W'(d0_s4[j]) + $signed(Q_W'(dp_s4[j])) - cc;
		end
	end

	always_ff @(posedge clk) begin
		proj_s5 <= proj_c;
		q1_s5   <= q1_c;
		q2_s5   <= q2_c;
		n_s5    <= n_s4;
	end

	// stage 6: split partial products of n . q
	logic signed [PP_W-1:0] lo1_c [3];
	logic signed [PP_W-1:0] hi1_c [3];
	logic signed [PP_W-1:0] lo2_c [3];
	logic signed [PP_W-1:0] hi2_c [3];
	logic signed [PP_W-1:0] lo1_s6[3];
	logic signed [PP_W-1:0] hi1_s6[3];
	logic signed [PP_W-1:0] lo2_s6[3];
	logic signed [PP_W-1:0] hi2_s6[3];
	logic [2:0]             proj_s6;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo1_c[j] = PP_W'($signed({1'b0, n_s5[j][NL_W-1:0]})) * PP_W'(q1_s5[j]);
			hi1_c[j] = PP_W'($signed(n_s5[j][N_W-1:NL_W])) * PP_W'(q1_s5[j]);
			lo2_c[j] = PP_W'($signed({1'b0, n_s5[j][NL_W-1:0]})) * PP_W'(q2_s5[j]);
			hi2_c[j] = PP_W'($signed(n_s5[j][N_W-1:NL_W])) * PP_W'(q2_s5[j]);
		end
	end

	always_ff @(posedge clk) begin
		lo1_s6  <= lo1_c;
		hi1_s6  <= hi1_c;
		lo2_s6  <= lo2_c;
		hi2_s6  <= hi2_c;
		proj_s6 <= proj_s5;
	end

	// stage 7: recombine products
	logic signed [PC_W-1:0] c1_c [3];
	logic signed [PC_W-1:0] c2_c [3];
	logic signed [PC_W-1:0] c1_s7[3];
	logic signed [PC_W-1:0] c2_s7[3];
	logic [2:0]             proj_s7;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			c1_c[j] = (PC_W'(hi1_s6[j]) <<< NL_W) + PC_W'(lo1_s6[j]);
			c2_c[j] = (PC_W'(hi2_s6[j]) <<< NL_W) + PC_W'(lo2_s6[j]);
		end
	end

	always_ff @(posedge clk) begin
		c1_s7   <= c1_c;
		c2_s7   <= c2_c;
		proj_s7 <= proj_s6;
	end

	// stage 8: plane sums, signs, result register
	logic signed [PS_W-1:0] s1_c, s2_c;
	logic                   plane_c;

	always_comb begin
		s1_c = PS_W'(c1_s7[0]) + PS_W'(c1_s7[1]) + PS_W'(c1_s7[2]);
		s2_c = PS_W'(c2_s7[0]) + PS_W'(c2_s7[1]) + PS_W'(c2_s7[2]);
		plane_c = !((s1_c != '0) && (s2_c != '0) &&
			(s1_c[PS_W-1] == s2_c[PS_W-1]));
	end

	always_ff @(posedge clk) begin
		plane_pass <= plane_c;
		xy_pass    <= proj_s7[0];
		yz_pass    <= proj_s7[1];
		zx_pass    <= proj_s7[2];
		overlap    <= plane_c & (&proj_s7);
	end

endmodule

`default_nettype wire

>>> tb/tb_triangle_voxel_overlap_test_unit.sv
`default_nettype none

module tb_triangle_voxel_overlap_test_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tvot_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 12;

	typedef struct {
		logic signed [COORD_W-1:0] vtx[9];
		logic [INDEX_BITS-1:0]     idx[3];
	} tri_voxel_t;

	typedef struct packed {
		logic overlap;
		logic plane;
		logic xy;
		logic yz;
		logic zx;
	} overlap_flags_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_W-1:0] vert0_x = '0, vert0_y = '0, vert0_z = '0;
	logic signed [COORD_W-1:0] vert1_x = '0, vert1_y = '0, vert1_z = '0;
	logic signed [COORD_W-1:0] vert2_x = '0, vert2_y = '0, vert2_z = '0;
	logic [INDEX_BITS-1:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
	logic done, overlap, plane_pass, xy_pass, yz_pass, zx_pass;

	triangle_voxel_overlap_test_unit dut (.*);

	always #10 clk = ~clk;

	longint grid_origin[3];
	longint voxel_unit[3];
	tri_voxel_t pending_q[$];
	overlap_flags_t flags_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	int gap_left = 0;

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic bit edges_pass(longint v[3][3], longint e[3][3], longint n[3],
			longint p[3], longint dp[3], int a, int b, int k);
		longint m0, m1, f, t0, t1;
		bit ok;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			m0 = -e[i][b];
			m1 = e[i][a];
			if (n[k] < 0) begin
				m0 = -m0;
				m1 = -m1;
			end
			t0 = dp[a] * m0;
			t1 = dp[b] * m1;
			f = m0 * (p[a] - v[i][a]) + m1 * (p[b] - v[i][b])
				+ (t0 > 0 ? t0 : 0) + (t1 > 0 ? t1 : 0);
			if (f < 0)
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic overlap_flags_t predict_overlap(tri_voxel_t it);
		longint v[3][3], e[3][3], n[3], p[3], dp[3], c;
		logic signed [127:0] s1, s2, nw, qw;
		overlap_flags_t r;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				v[i][j] = longint'(it.vtx[i*3+j]) - grid_origin[j];
		for (int j = 0; j < 3; j++) begin
			e[0][j] = v[1][j] - v[0][j];
			e[1][j] = v[2][j] - v[1][j];
			e[2][j] = v[0][j] - v[2][j];
		end
		n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
		n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
		n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
		s1 = '0;
		s2 = '0;
		for (int j = 0; j < 3; j++) begin
			p[j] = longint'(it.idx[j]) * voxel_unit[j] - HALF_EPS_LSB;
			dp[j] = voxel_unit[j] + EPS_LSB;
			c = n[j] > 0 ? dp[j] : 0;
			nw = n[j];
			qw = p[j] + c - v[0][j];
			s1 = s1 + nw * qw;
			qw = p[j] + dp[j] - c - v[0][j];
			s2 = s2 + nw * qw;
		end
		r.plane = !(s1 != 0 && s2 != 0 && (s1 < 0) == (s2 < 0));
		r.xy = edges_pass(v, e, n, p, dp, 0, 1, 2);
		r.yz = edges_pass(v, e, n, p, dp, 1, 2, 0);
		r.zx = edges_pass(v, e, n, p, dp, 2, 0, 1);
		r.overlap = r.plane & r.xy & r.yz & r.zx;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		tri_voxel_t it;
		logic nxt;
		nxt = start;
		if (start && !busy) begin
			nxt = 1'b0;
		end
		if (!nxt && arst_n) begin
			if (gap_left > 0)
				gap_left <= gap_left - 1;
			else if (pending_q.size() > 0) begin
				it = pending_q.pop_front();
				flags_q.push_back(predict_overlap(it));
				{vert0_x, vert0_y, vert0_z} <= {it.vtx[0], it.vtx[1], it.vtx[2]};
				{vert1_x, vert1_y, vert1_z} <= {it.vtx[3], it.vtx[4], it.vtx[5]};
				{vert2_x, vert2_y, vert2_z} <= {it.vtx[6], it.vtx[7], it.vtx[8]};
				{voxel_x, voxel_y, voxel_z} <= {it.idx[0], it.idx[1], it.idx[2]};
				nxt = 1'b1;
				gap_left <= pick_gap();
			end
		end
		start <= nxt;
	end

	// monitor; expectation is queued when the transaction is launched
	always @(posedge clk) begin
		overlap_flags_t want, got;
		if (done) begin
			got = '{overlap, plane_pass, xy_pass, yz_pass, zx_pass};
			if (flags_q.size() == 0)
				report("result with no transaction outstanding");
			else begin
				want = flags_q.pop_front();
				if (got.overlap !== want.overlap)
					report($sformatf("overlap %b exp %b", got.overlap, want.overlap));
				if (got.plane !== want.plane)
					report($sformatf("plane_pass %b exp %b", got.plane, want.plane));
				if (got.xy !== want.xy)
					report($sformatf("xy_pass %b exp %b", got.xy, want.xy));
				if (got.yz !== want.yz)
					report($sformatf("yz_pass %b exp %b", got.yz, want.yz));
				if (got.zx !== want.zx)
					report($sformatf("zx_pass %b exp %b", got.zx, want.zx));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("triangle_voxel_overlap_test_unit regression: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		if (idx < 3)
			grid_origin[idx] = longint'($signed(COORD_W'(val)));
		else if (idx < 6)
			voxel_unit[idx-3] = longint'(val & 64'h7F_FFFF);
	endtask

	task automatic set_grid(input longint ox, oy, oz, ux, uy, uz);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_UNIT_X, ux);
		write_reg(CFG_UNIT_Y, uy);
		write_reg(CFG_UNIT_Z, uz);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || start || flags_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] clamp24(longint x);
		if (x > 64'sd8388607)
			return 24'sh7FFFFF;
		if (x < -64'sd8388608)
			return 24'sh800000;
		return COORD_W'(x);
	endfunction

	// triangle scattered around the chosen voxel
	function automatic tri_voxel_t near_voxel(int kind);
		tri_voxel_t it;
		longint ctr, span;
		int pick;
		for (int j = 0; j < 3; j++)
			it.idx[j] = $urandom_range(0, 3) == 0 ? INDEX_BITS'($urandom)
				: INDEX_BITS'($urandom_range(0, 15));
		pick = $urandom_range(0, 2);
		for (int j = 0; j < 3; j++) begin
			ctr = grid_origin[j] + longint'(it.idx[j]) * voxel_unit[j] + voxel_unit[j] / 2;
			span = 2 * voxel_unit[j] + 8;
			for (int i = 0; i < 3; i++) begin
				it.vtx[i*3+j] = clamp24(ctr + longint'($urandom_range(0, 2 * span)) - span);
				// flat in one axis, or collapsed onto a vertex
				if (kind == 1 && j == pick && i > 0)
					it.vtx[i*3+j] = it.vtx[j];
				if (kind == 2 && i == 2)
					it.vtx[6+j] = it.vtx[3+j];
			end
		end
		return it;
	endfunction

	function automatic tri_voxel_t any_item();
		tri_voxel_t it;
		for (int i = 0; i < 9; i++)
			it.vtx[i] = COORD_W'($urandom);
		for (int j = 0; j < 3; j++)
			it.idx[j] = INDEX_BITS'($urandom);
		return it;
	endfunction

	task automatic random_items(input int count);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				pending_q.push_back(near_voxel(0));
			else if (r < 78)
				pending_q.push_back(near_voxel(1));
			else if (r < 85)
				pending_q.push_back(near_voxel(2));
			else
				pending_q.push_back(any_item());
		end
	endtask

	function automatic tri_voxel_t fill_item(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b, logic signed [COORD_W-1:0] c,
			logic [INDEX_BITS-1:0] ix);
		tri_voxel_t it;
		for (int j = 0; j < 3; j++) begin
			it.vtx[j] = a;
			it.vtx[3+j] = b;
			it.vtx[6+j] = c;
			it.idx[j] = ix;
		end
		return it;
	endfunction

	initial begin
		tri_voxel_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		grid_origin = '{0, 0, 0};
		voxel_unit = '{4096, 4096, 4096};

		// directed
		set_grid(0, 0, 0, 4096, 4096, 4096);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_SPARE_A;
		cfg_data <= '1;
		@(posedge clk);
		cfg_index <= CFG_SPARE_B;
		@(posedge clk);
		cfg_write <= 1'b0;
		no_idle = 1'b1;
		pending_q.push_back(fill_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '1));
		pending_q.push_back(fill_item(24'sh800000, 24'sh800000, 24'sh800000, '0));
		pending_q.push_back(fill_item(24'sh800000, 24'sh7FFFFF, 24'sh000000, '0));
		pending_q.push_back(fill_item(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, '1));
		pending_q.push_back(fill_item(24'sd100, 24'sd100, 24'sd100, '0));
		it = fill_item(24'sd0, 24'sd0, 24'sd0, '0);
		it.vtx[3] = 24'sd4096;
		it.vtx[7] = 24'sd4096;
		pending_q.push_back(it);
		it.idx = '{1, 0, 0};
		pending_q.push_back(it);
		it.idx = '{5, 5, 5};
		pending_q.push_back(it);
		it = fill_item(-24'sd8, -24'sd8, -24'sd8, '0);
		it.vtx[4] = 24'sd8200;
		it.vtx[8] = 24'sd8200;
		pending_q.push_back(it);
		for (int k = 0; k < 10; k++)
			pending_q.push_back(near_voxel(k % 3));
		drain();

		no_idle = 1'b0;
		random_items(380);
		drain();

		set_grid(24'sh7FFFFF, -8388608, 12345, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
		random_items(300);
		drain();

		set_grid(-8388608, 24'sh7FFFFF, 0, 0, 1, 0);
		random_items(300);
		drain();

		no_idle = 1'b1;
		set_grid(-4096, 2048, 777, 1, 0, 2);
		random_items(300);
		drain();

		no_idle = 1'b0;
		for (int ph = 0; ph < 3; ph++) begin
			set_grid(longint'($signed(COORD_W'($urandom))) / 64,
				longint'($signed(COORD_W'($urandom))) / 64,
				longint'($signed(COORD_W'($urandom))) / 64,
				$urandom_range(1, 20000), $urandom_range(1, 20000), $urandom_range(1, 20000));
			random_items(200);
			drain();
		end

		if (errors == 0)
			$display("triangle_voxel_overlap_test_unit regression: pass");
		else
			$display("triangle_voxel_overlap_test_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
src/tvot_pkg.sv
src/triangle_voxel_overlap_test_unit.sv
tb/tb_triangle_voxel_overlap_test_unit.sv
